// ===== src/pcc_pkg.sv =====
// shared constants and a helper for the pose consensus clusterer
package pcc_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int COORD_W      = 24;
  localparam int NUM_COORDS   = 6;
  localparam int SIZE_W       = 16;
  localparam int CIDX_W       = $clog2(MAX_CLUSTERS);
  localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);
  localparam int MEM_DEPTH    = MAX_CLUSTERS * NUM_COORDS;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);
  localparam int DIV_STEPS    = 25;
  localparam int SQRT_STEPS   = 24;

  // register indexes on the configuration port
  localparam logic [1:0] REG_THRESH = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_SHIFT  = 2'd3;

  localparam logic [22:0]        THRESH_RST = 23'd6554;
  localparam logic signed [23:0] HEIGHT_RST = 24'sd29819;
  localparam logic signed [23:0] SHIFT_RST  = 24'sd3932;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  // clamp to the signed coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [COORD_W+1:0] v);
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] lo;
    hi = (COORD_W+2)'(2 ** (COORD_W - 1) - 1);
    lo = -hi - (COORD_W+2)'(1);
    if (v > hi) begin
      sat_coord = hi[COORD_W-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_W-1:0];
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

// ===== src/pose_consensus_clusterer_unit.sv =====
// pose consensus clusterer: leader clustering of pose samples with consensus result
//
//  channel  | handshake            | words
//  ---------+----------------------+------------------------------------------
//  sample   | in_valid / in_ready  | pos_x..dir_z, last_sample
//  result   | out_valid / out_ready| hole_x..normal_z, winner_size, table_overflow
//  config   | apb psel/penable     | match_threshold_sq, apply_offset,
//           |                      | fixed_height, side_shift at 0x0,0x4,0x8,0xc
//
// processing: one sample at a time; the sample is compared with each cluster in use, and
//   each matching cluster gets six mean updates through the shared 25-step divider; an
//   unmatched sample opens a cluster while there is room. a last sample adds a scan of
//   the cluster sizes, a 24-step square root and three 25-step divides.
// the coordinate memory (one address shared by read and write, registered read) sets
//   the per-coordinate pace; the divider sets the cost of a match.
// reset: synchronous, clears control and counts, loads the configuration defaults;
//   memory needs no sweep, entries are written before they are read.
// stalls: a waiting result does not block samples; only a last sample waits
//   for the result register to empty.
module pose_consensus_clusterer_unit (
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [23:0] dir_x,
  input  logic signed [23:0] dir_y,
  input  logic signed [23:0] dir_z,
  input  logic               last_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] hole_x,
  output logic signed [23:0] hole_y,
  output logic signed [23:0] hole_z,
  output logic signed [23:0] normal_x,
  output logic signed [23:0] normal_y,
  output logic signed [23:0] normal_z,
  output logic [15:0]        winner_size,
  output logic               table_overflow,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = pcc_pkg::COORD_W;
  localparam int AW = pcc_pkg::ADDR_W;
  localparam int IW = pcc_pkg::CIDX_W;
  localparam int NW = pcc_pkg::CNT_W;
  localparam int SW = pcc_pkg::SIZE_W;

  // sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_D_RD   = 5'd1;
  localparam logic [4:0] S_D_DIF  = 5'd2;
  localparam logic [4:0] S_D_SQ   = 5'd3;
  localparam logic [4:0] S_D_CMP  = 5'd4;
  localparam logic [4:0] S_U_RD   = 5'd5;
  localparam logic [4:0] S_U_MUL  = 5'd6;
  localparam logic [4:0] S_U_PRE  = 5'd7;
  localparam logic [4:0] S_U_ABS  = 5'd8;
  localparam logic [4:0] S_DIV    = 5'd9;
  localparam logic [4:0] S_U_WR   = 5'd10;
  localparam logic [4:0] S_U_SZ   = 5'd11;
  localparam logic [4:0] S_NEXT   = 5'd12;
  localparam logic [4:0] S_NEW    = 5'd13;
  localparam logic [4:0] S_NEW_WR = 5'd14;
  localparam logic [4:0] S_AFTER  = 5'd15;
  localparam logic [4:0] S_B_SCAN = 5'd16;
  localparam logic [4:0] S_F_RD   = 5'd17;
  localparam logic [4:0] S_F_CAP  = 5'd18;
  localparam logic [4:0] S_F_SQ   = 5'd19;
  localparam logic [4:0] S_SQ_INI = 5'd20;
  localparam logic [4:0] S_SQRT   = 5'd21;
  localparam logic [4:0] S_N_LD   = 5'd22;
  localparam logic [4:0] S_N_END  = 5'd23;
  localparam logic [4:0] S_OFS    = 5'd24;
  localparam logic [4:0] S_O_M1   = 5'd25;
  localparam logic [4:0] S_O_M2   = 5'd26;
  localparam logic [4:0] S_O_M3   = 5'd27;
  localparam logic [4:0] S_EMIT   = 5'd28;

  logic [4:0] state;

  // configuration registers
  logic [22:0]          thr;
  logic                 apply_off;
  logic signed [CW-1:0] fix_h;
  logic signed [CW-1:0] side_sh;

  // latched sample
  logic signed [CW-1:0] x_q [pcc_pkg::NUM_COORDS];
  logic                 last_q;

  // cluster bookkeeping
  logic [SW-1:0] sizes [pcc_pkg::MAX_CLUSTERS];
  logic [NW-1:0] in_use;
  logic          ovf;
  logic          found;
  logic [NW-1:0] c;
  logic [2:0]    i;

  // distance
  logic signed [CW:0] diff;
  logic [50:0]        acc;

  // mean update
  logic signed [41:0] num;
  logic signed [43:0] nval;

  // shared restoring divider
  logic [24:0] dv_rem;
  logic [24:0] dv_sh;
  logic [24:0] dv_quo;
  logic [24:0] dv_d;
  logic [4:0]  dv_cnt;
  logic        dv_neg;
  logic        nphase;

  // result path
  logic [IW-1:0]        best;
  logic [SW-1:0]        best_size;
  logic signed [CW-1:0] crd [pcc_pkg::NUM_COORDS];
  logic signed [CW-1:0] nrm [3];
  logic [47:0]          s_acc;
  logic [47:0]          sq_v;
  logic [47:0]          sq_res;
  logic [47:0]          sq_bit;
  logic [4:0]           sq_cnt;
  logic signed [47:0]   prod;

  // coordinate memory
  logic signed [CW-1:0] coord_mem [pcc_pkg::MEM_DEPTH];
  logic signed [CW-1:0] mem_q;
  logic                 mem_we;
  logic signed [CW-1:0] mem_wdata;
  logic [AW-1:0]        addr;
  logic [IW-1:0]        idx_sel;

  // ---------------- combinational helpers ----------------
  logic [IW-1:0]        ci;
  logic [SW-1:0]        n_cur;
  logic [16:0]          dval;
  logic [17:0]          dden;
  logic signed [CW-1:0] x_sel;
  logic signed [40:0]   mprod;
  logic signed [49:0]   dsq;
  logic [43:0]          a_mean;
  logic [25:0]          dv_t;
  logic                 dv_ge;
  logic [24:0]          q_s;
  logic signed [CW-1:0] dsel;
  logic signed [47:0]   dir_sq;
  logic [CW-1:0]        dmag;
  logic [43:0]          a_norm;
  logic [47:0]          sq_try;
  logic signed [47:0]   prod_rnd;
  logic signed [CW+1:0] ofs_sum;
  logic signed [CW+1:0] ofs_dif;
  logic                 cfg_wr;

  assign ci     = c[IW-1:0];
  assign n_cur  = sizes[ci];
  assign dval   = {1'b0, n_cur} + 17'd1;
  assign dden   = {dval, 1'b0};
  assign x_sel  = x_q[i];
  assign mprod  = mem_q * $signed({1'b0, n_cur});
  assign dsq    = diff * diff;
  // floor for negative numerators: -floor((|n| + d - 1) / d), and ~n = -n - 1
  assign a_mean = nval[43] ? (~nval + {26'd0, dden}) : nval;
  assign dv_t   = {dv_rem, dv_sh[24]};
  assign dv_ge  = dv_t >= {1'b0, dv_d};
  assign q_s    = dv_neg ? (~dv_quo + 25'd1) : dv_quo;
  assign dsel   = crd[3'(i) + 3'd3];
  assign dir_sq = dsel * dsel;
  assign dmag   = dsel[CW-1] ? (~dsel + 24'sd1) : dsel;
  assign a_norm = {4'd0, dmag, 16'd0} + {20'd0, sq_res[24:1]};
  assign sq_try = sq_res + sq_bit;
  assign prod_rnd = (prod + 48'sd32768) >>> 16;
  assign ofs_sum  = {{2{crd[0][CW-1]}}, crd[0]} + prod_rnd[CW+1:0];
  assign ofs_dif  = {{2{crd[1][CW-1]}}, crd[1]} - prod_rnd[CW+1:0];

  // memory address: cluster slot times six plus coordinate
  always_comb begin
    if (state == S_NEW_WR) begin
      idx_sel = in_use[IW-1:0];
    end else if (state == S_F_RD || state == S_F_CAP) begin
      idx_sel = best;
    end else begin
      idx_sel = ci;
    end
  end
  assign addr = AW'(idx_sel) * AW'(6) + AW'(i);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = x_sel;
    if (state == S_U_WR) begin
      mem_we    = 1'b1;
      mem_wdata = q_s[CW-1:0];
    end else if (state == S_NEW_WR) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      coord_mem[addr] <= mem_wdata;
    end
    mem_q <= coord_mem[addr];
  end

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr       <= pcc_pkg::THRESH_RST;
      apply_off <= 1'b0;
      fix_h     <= pcc_pkg::HEIGHT_RST;
      side_sh   <= pcc_pkg::SHIFT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pcc_pkg::REG_THRESH: thr       <= pwdata[22:0];
        pcc_pkg::REG_OFFSET: apply_off <= pwdata[0];
        pcc_pkg::REG_HEIGHT: fix_h     <= pwdata[23:0];
        pcc_pkg::REG_SHIFT:  side_sh   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pcc_pkg::REG_THRESH: prdata = {9'd0, thr};
      pcc_pkg::REG_OFFSET: prdata = {31'd0, apply_off};
      pcc_pkg::REG_HEIGHT: prdata = {8'd0, fix_h};
      pcc_pkg::REG_SHIFT:  prdata = {8'd0, side_sh};
      default:             prdata = 32'd0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_use    <= '0;
      ovf       <= 1'b0;
      found     <= 1'b0;
      c         <= '0;
      i         <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < pcc_pkg::MAX_CLUSTERS; k++) begin
        sizes[k] <= '0;
      end
    end else begin
      // the emit state reloads the result register itself
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_q[0] <= pos_x;
            x_q[1] <= pos_y;
            x_q[2] <= pos_z;
            x_q[3] <= dir_x;
            x_q[4] <= dir_y;
            x_q[5] <= dir_z;
            last_q <= last_sample;
            found  <= 1'b0;
            c      <= '0;
            i      <= '0;
            acc    <= '0;
            state  <= (in_use == '0) ? S_NEW : S_D_RD;
          end
        end
        // squared distance, one coordinate per pass
        S_D_RD: state <= S_D_DIF;
        S_D_DIF: begin
          diff  <= {mem_q[CW-1], mem_q} - {x_sel[CW-1], x_sel};
          state <= S_D_SQ;
        end
        S_D_SQ: begin
          acc <= acc + {1'b0, dsq};
          if (i == 3'd5) begin
            i     <= '0;
            state <= S_D_CMP;
          end else begin
            i     <= i + 3'd1;
            state <= S_D_RD;
          end
        end
        S_D_CMP: begin
          if (acc < {12'd0, thr, 16'd0}) begin
            found <= 1'b1;
            state <= S_U_RD;
          end else begin
            state <= S_NEXT;
          end
        end
        // running mean: round((mean*n + x) / (n+1)), ties up
        S_U_RD: state <= S_U_MUL;
        S_U_MUL: begin
          num   <= {mprod[40], mprod} + {{18{x_sel[CW-1]}}, x_sel};
          state <= S_U_PRE;
        end
        S_U_PRE: begin
          nval  <= {num[41], num, 1'b0} + {27'd0, dval};
          state <= S_U_ABS;
        end
        S_U_ABS: begin
          dv_rem <= {6'd0, a_mean[43:25]};
          dv_sh  <= a_mean[24:0];
          dv_d   <= {7'd0, dden};
          dv_neg <= nval[43];
          dv_cnt <= '0;
          nphase <= 1'b0;
          state  <= S_DIV;
        end
        S_DIV: begin
          dv_rem <= dv_ge ? 25'(dv_t - {1'b0, dv_d}) : dv_t[24:0];
          dv_sh  <= {dv_sh[23:0], 1'b0};
          dv_quo <= {dv_quo[23:0], dv_ge};
          dv_cnt <= dv_cnt + 5'd1;
          if (dv_cnt == 5'(pcc_pkg::DIV_STEPS - 1)) begin
            state <= nphase ? S_N_END : S_U_WR;
          end
        end
        S_U_WR: begin
          if (i == 3'd5) begin
            i     <= '0;
            state <= S_U_SZ;
          end else begin
            i     <= i + 3'd1;
            state <= S_U_RD;
          end
        end
        S_U_SZ: begin
          if (n_cur != pcc_pkg::SIZE_MAX) begin
            sizes[ci] <= n_cur + SW'(1);
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          i   <= '0;
          acc <= '0;
          if ({1'b0, c} + 1'b1 < {1'b0, in_use}) begin
            c     <= c + NW'(1);
            state <= S_D_RD;
          end else begin
            state <= S_NEW;
          end
        end
        // unmatched sample opens a cluster or is dropped
        S_NEW: begin
          i <= '0;
          if (found) begin
            state <= S_AFTER;
          end else if (in_use < NW'(pcc_pkg::MAX_CLUSTERS)) begin
            state <= S_NEW_WR;
          end else begin
            ovf   <= 1'b1;
            state <= S_AFTER;
          end
        end
        S_NEW_WR: begin
          if (i == 3'd5) begin
            sizes[in_use[IW-1:0]] <= SW'(1);
            in_use <= in_use + NW'(1);
            i      <= '0;
            state  <= S_AFTER;
          end else begin
            i <= i + 3'd1;
          end
        end
        S_AFTER: begin
          c         <= '0;
          best      <= '0;
          best_size <= '0;
          state     <= last_q ? S_B_SCAN : S_IDLE;
        end
        // first largest cluster
        S_B_SCAN: begin
          if (c < in_use) begin
            if (n_cur > best_size) begin
              best_size <= n_cur;
              best      <= ci;
            end
            c <= c + NW'(1);
          end else if (best_size == '0) begin
            for (int k = 0; k < pcc_pkg::NUM_COORDS; k++) begin
              crd[k] <= '0;
            end
            for (int k = 0; k < 3; k++) begin
              nrm[k] <= '0;
            end
            state <= S_EMIT;
          end else begin
            i     <= '0;
            state <= S_F_RD;
          end
        end
        S_F_RD: state <= S_F_CAP;
        S_F_CAP: begin
          crd[i] <= mem_q;
          if (i == 3'd5) begin
            i     <= '0;
            s_acc <= '0;
            state <= S_F_SQ;
          end else begin
            i     <= i + 3'd1;
            state <= S_F_RD;
          end
        end
        S_F_SQ: begin
          s_acc <= s_acc + dir_sq;
          if (i == 3'd2) begin
            i     <= '0;
            state <= S_SQ_INI;
          end else begin
            i <= i + 3'd1;
          end
        end
        S_SQ_INI: begin
          if (s_acc == '0) begin
            for (int k = 0; k < 3; k++) begin
              nrm[k] <= '0;
            end
            state <= S_OFS;
          end else begin
            sq_v   <= s_acc;
            sq_res <= '0;
            sq_bit <= 48'd1 << 46;
            sq_cnt <= '0;
            state  <= S_SQRT;
          end
        end
        // integer square root, one bit pair per cycle
        S_SQRT: begin
          if (sq_v >= sq_try) begin
            sq_v   <= sq_v - sq_try;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'(pcc_pkg::SQRT_STEPS - 1)) begin
            i     <= '0;
            state <= S_N_LD;
          end
        end
        // normal component: round(|d| * 65536 / r), ties away from zero
        S_N_LD: begin
          dv_rem <= {6'd0, a_norm[43:25]};
          dv_sh  <= a_norm[24:0];
          dv_d   <= sq_res[24:0];
          dv_neg <= dsel[CW-1];
          dv_cnt <= '0;
          nphase <= 1'b1;
          state  <= S_DIV;
        end
        S_N_END: begin
          nrm[i[1:0]] <= q_s[CW-1:0];
          if (i == 3'd2) begin
            state <= S_OFS;
          end else begin
            i     <= i + 3'd1;
            state <= S_N_LD;
          end
        end
        S_OFS: state <= apply_off ? S_O_M1 : S_EMIT;
        S_O_M1: begin
          prod  <= nrm[1] * side_sh;
          state <= S_O_M2;
        end
        S_O_M2: begin
          crd[0] <= pcc_pkg::sat_coord(ofs_sum);
          prod   <= nrm[0] * side_sh;
          state  <= S_O_M3;
        end
        S_O_M3: begin
          crd[1] <= pcc_pkg::sat_coord(ofs_dif);
          crd[2] <= fix_h;
          state  <= S_EMIT;
        end
        // hand the result over and start a fresh set
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            hole_x         <= crd[0];
            hole_y         <= crd[1];
            hole_z         <= crd[2];
            normal_x       <= nrm[0];
            normal_y       <= nrm[1];
            normal_z       <= nrm[2];
            winner_size    <= best_size;
            table_overflow <= ovf;
            out_valid      <= 1'b1;
            in_use         <= '0;
            ovf            <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= NW'(pcc_pkg::MAX_CLUSTERS))
    else $error("cluster count beyond table size");

  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sample taken while another is in flight");

  a_normal_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (normal_x <= 24'sd65536 && normal_x >= -24'sd65536 &&
                   normal_y <= 24'sd65536 && normal_y >= -24'sd65536 &&
                   normal_z <= 24'sd65536 && normal_z >= -24'sd65536))
    else $error("normal component exceeds unit length");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && winner_size == '0) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("empty store gave a non-zero normal");

endmodule
